// File: sv/sstf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, microcode types and the control program of the SSTF disk scheduler.
// Depends on nothing; imported by the scheduler top level.
package sstf_pkg;

  localparam int MAX_REQUESTS_DEF = 64;
  localparam int TRACK_BITS_DEF   = 16;
  localparam int TRACK_W          = 16;
  localparam int TOTAL_W          = 22;
  localparam int INDEX_W          = 6;
  localparam int STEP_W           = 3;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_LOAD  = 3'd0;
  localparam step_t STEP_INIT  = 3'd1;
  localparam step_t STEP_SCAN0 = 3'd2;
  localparam step_t STEP_SCAN  = 3'd3;
  localparam step_t STEP_EMIT  = 3'd4;
  localparam step_t STEP_DONE  = 3'd5;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_INIT,
    OP_SCAN_START,
    OP_SCAN,
    OP_EMIT,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_STAY_LOAD,
    COND_SCAN_MORE,
    COND_MORE_MOVES
  } cond_t;

  typedef struct packed {
    logic  busy;
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // When the condition holds the sequencer jumps to target, else it steps on by one.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      STEP_LOAD:  w = '{busy: 1'b0, op: OP_LOAD,       cond: COND_STAY_LOAD,  target: STEP_LOAD};
      STEP_INIT:  w = '{busy: 1'b1, op: OP_INIT,       cond: COND_NEVER,      target: STEP_LOAD};
      STEP_SCAN0: w = '{busy: 1'b1, op: OP_SCAN_START, cond: COND_NEVER,      target: STEP_LOAD};
      STEP_SCAN:  w = '{busy: 1'b1, op: OP_SCAN,       cond: COND_SCAN_MORE,  target: STEP_SCAN};
      STEP_EMIT:  w = '{busy: 1'b1, op: OP_EMIT,       cond: COND_MORE_MOVES, target: STEP_SCAN0};
      STEP_DONE:  w = '{busy: 1'b1, op: OP_DONE,       cond: COND_ALWAYS,     target: STEP_LOAD};
      default:    w = '{busy: 1'b1, op: OP_DONE,       cond: COND_ALWAYS,     target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

// File: sv/sstf_disk_scheduler.sv
`timescale 1ns / 1ps
// Shortest-seek-time-first disk scheduler driven by a microcoded sequencer.
// Depends on sstf_pkg (control program, constants) and sstf_ram (request store).
// Loading accepts one request per cycle while busy is low. A batch of n requests then keeps
// busy high through an init step, n moves and a done step: each move reads all n stored
// entries through the single RAM read port, one per cycle, between a setup and an emit
// step. The receiver cannot stall, and each move is on the ports for one cycle.
// Synchronous active-low reset empties the batch and zeroes start_track.
module sstf_disk_scheduler #(
  parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF,
  parameter int TRACK_BITS   = sstf_pkg::TRACK_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [sstf_pkg::TRACK_W-1:0] in_track,
  input  logic                         in_last_request,
  input  logic                         cfg_we,
  input  logic [sstf_pkg::TRACK_W-1:0] cfg_wdata,
  output logic                         out_valid,
  output logic [sstf_pkg::TRACK_W-1:0] out_from_track,
  output logic [sstf_pkg::TRACK_W-1:0] out_to_track,
  output logic [sstf_pkg::TRACK_W-1:0] out_seek_distance,
  output logic [sstf_pkg::TOTAL_W-1:0] out_total_seek,
  output logic [sstf_pkg::INDEX_W-1:0] out_request_index,
  output logic                         out_last_move
);

  import sstf_pkg::*;

  localparam int SW = (TRACK_BITS < TRACK_W) ? TRACK_BITS : TRACK_W;
  localparam int IW = $clog2(MAX_REQUESTS);
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int XW = IW + INDEX_W;

  step_t             step_r, step_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [IW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [TRACK_W-1:0] start_track_r, start_track_nxt;
  logic [MAX_REQUESTS-1:0] served_r, served_nxt;
  logic [SW-1:0]     head_r, head_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic              found_r, found_nxt;
  logic [SW-1:0]     best_d_r, best_d_nxt;
  logic [IW-1:0]     best_i_r, best_i_nxt;
  logic [SW-1:0]     best_trk_r, best_trk_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [TRACK_W-1:0] out_from_r, out_from_nxt;
  logic [TRACK_W-1:0] out_to_r, out_to_nxt;
  logic [TRACK_W-1:0] out_dist_r, out_dist_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic [INDEX_W-1:0] out_index_r, out_index_nxt;
  logic              out_last_r, out_last_nxt;

  uword_t            uw;
  logic              accept;
  logic              close_batch;
  logic              scan_last;
  logic              move_last;
  logic              cond_met;
  logic              ram_we;
  logic [IW-1:0]     ram_raddr;
  logic [SW-1:0]     ram_rdata;
  logic [SW-1:0]     cur_d;
  logic [TOTAL_W:0]  sum;
  logic [XW-1:0]     index_ext;

  sstf_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_REQUESTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[IW-1:0]),
    .wdata(in_track[SW-1:0]),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    uw          = ucode(step_r);
    busy        = uw.busy;
    accept      = start && !busy;
    close_batch = accept && (in_last_request || (count_r == CW'(MAX_REQUESTS - 1)));
    scan_last   = (CW'(rd_idx_r) == (count_r - CW'(1)));
    move_last   = ((k_r + CW'(1)) == count_r);
    cur_d       = (head_r >= ram_rdata) ? (head_r - ram_rdata) : (ram_rdata - head_r);
    sum         = {1'b0, total_r} + (TOTAL_W + 1)'(best_d_r);
    index_ext   = XW'(best_i_r);

    step_nxt        = step_r;
    count_nxt       = count_r;
    j_nxt           = j_r;
    k_nxt           = k_r;
    rd_idx_nxt      = rd_idx_r;
    start_track_nxt = cfg_we ? cfg_wdata : start_track_r;
    served_nxt      = served_r;
    head_nxt        = head_r;
    total_nxt       = total_r;
    found_nxt       = found_r;
    best_d_nxt      = best_d_r;
    best_i_nxt      = best_i_r;
    best_trk_nxt    = best_trk_r;
    out_valid_nxt   = 1'b0;
    out_from_nxt    = out_from_r;
    out_to_nxt      = out_to_r;
    out_dist_nxt    = out_dist_r;
    out_total_nxt   = out_total_r;
    out_index_nxt   = out_index_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_raddr       = j_r[IW-1:0];

    case (uw.op)
      OP_LOAD: begin
        if (accept) begin
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_INIT: begin
        served_nxt = '0;
        head_nxt   = start_track_r[SW-1:0];
        total_nxt  = '0;
        k_nxt      = '0;
      end
      OP_SCAN_START: begin
        ram_raddr  = '0;
        rd_idx_nxt = '0;
        j_nxt      = CW'(1);
        found_nxt  = 1'b0;
      end
      OP_SCAN: begin
        j_nxt      = j_r + CW'(1);
        rd_idx_nxt = j_r[IW-1:0];
        if (!served_r[rd_idx_r] && (!found_r || (cur_d < best_d_r))) begin
          found_nxt    = 1'b1;
          best_d_nxt   = cur_d;
          best_i_nxt   = rd_idx_r;
          best_trk_nxt = ram_rdata;
        end
      end
      OP_EMIT: begin
        out_valid_nxt        = 1'b1;
        out_from_nxt         = TRACK_W'(head_r);
        out_to_nxt           = TRACK_W'(best_trk_r);
        out_dist_nxt         = TRACK_W'(best_d_r);
        out_total_nxt        = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
        out_index_nxt        = index_ext[INDEX_W-1:0];
        out_last_nxt         = move_last;
        total_nxt            = out_total_nxt;
        served_nxt[best_i_r] = 1'b1;
        head_nxt             = best_trk_r;
        k_nxt                = k_r + CW'(1);
      end
      OP_DONE: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase

    case (uw.cond)
      COND_ALWAYS:     cond_met = 1'b1;
      COND_NEVER:      cond_met = 1'b0;
      COND_STAY_LOAD:  cond_met = !close_batch;
      COND_SCAN_MORE:  cond_met = !scan_last;
      COND_MORE_MOVES: cond_met = !move_last;
      default:         cond_met = 1'b1;
    endcase

    step_nxt = cond_met ? uw.target : (step_r + step_t'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r        <= STEP_LOAD;
      count_r       <= '0;
      start_track_r <= '0;
      served_r      <= '0;
      out_valid_r   <= 1'b0;
      found_r       <= 1'b0;
      head_r        <= '0;
      total_r       <= '0;
    end else begin
      step_r        <= step_nxt;
      count_r       <= count_nxt;
      start_track_r <= start_track_nxt;
      served_r      <= served_nxt;
      out_valid_r   <= out_valid_nxt;
      found_r       <= found_nxt;
      head_r        <= head_nxt;
      total_r       <= total_nxt;
    end
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_d_r    <= best_d_nxt;
    best_i_r    <= best_i_nxt;
    best_trk_r  <= best_trk_nxt;
    out_from_r  <= out_from_nxt;
    out_to_r    <= out_to_nxt;
    out_dist_r  <= out_dist_nxt;
    out_total_r <= out_total_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_from_track    = out_from_r;
  assign out_to_track      = out_to_r;
  assign out_seek_distance = out_dist_r;
  assign out_total_seek    = out_total_r;
  assign out_request_index = out_index_r;
  assign out_last_move     = out_last_r;

`ifndef NO_ASSERTIONS
  a_valid_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(step_r == STEP_EMIT))
    else $error("move strobe without an emit step");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_REQUESTS))
    else $error("request count beyond store depth");

  a_emit_unserved: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_EMIT) |-> (found_r && !served_r[best_i_r]))
    else $error("emitting a request that is already served");

  a_batch_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> (count_r == '0) && !busy)
    else $error("store not emptied after the last move");
`endif

endmodule

// File: sv/sstf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the request store of the SSTF scheduler.
module sstf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: bench/sstf_disk_scheduler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SSTF disk scheduler: loads batches of track requests and
// checks every emitted head move against a scoreboard that replays the seek order.
// Depends on sstf_pkg and the sstf_disk_scheduler top level.
module sstf_disk_scheduler_tb;
  import sstf_pkg::*;

  localparam int BATCH_MAX       = MAX_REQUESTS_DEF;
  localparam int RANDOM_REQUESTS = 250;
  localparam int CYCLE_LIMIT     = 500000;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

  typedef logic [TRACK_W-1:0] track_t;

  typedef struct packed {
    track_t             from_trk;
    track_t             to_trk;
    track_t             seek_d;
    logic [TOTAL_W-1:0] total;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } head_move_t;

  class seek_scoreboard;
    track_t     start_track = '0;
    track_t     batch_tracks[$];
    head_move_t expected_moves[$];
    int         errors = 0;

    task report(input string msg);
      if (errors < 40) $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    // A batch closes on the last request or when the store is full; the whole seek
    // order is worked out then.
    function void note_request(input track_t trk, input logic last);
      bit                 served[BATCH_MAX];
      track_t             head;
      track_t             d;
      track_t             best_d;
      int                 best_i;
      bit                 found;
      logic [TOTAL_W:0]   total;
      head_move_t         m;
      int                 n;
      batch_tracks.push_back(trk);
      if (!last && batch_tracks.size() < BATCH_MAX) return;
      n = batch_tracks.size();
      for (int j = 0; j < BATCH_MAX; j++) served[j] = 1'b0;
      head  = start_track;
      total = '0;
      for (int k = 0; k < n; k++) begin
        found  = 1'b0;
        best_d = '0;
        best_i = 0;
        for (int j = 0; j < n; j++) begin
          if (!served[j]) begin
            d = (head >= batch_tracks[j]) ? head - batch_tracks[j] : batch_tracks[j] - head;
            if (!found || d < best_d) begin
              found  = 1'b1;
              best_d = d;
              best_i = j;
            end
          end
        end
        served[best_i] = 1'b1;
        total = total + best_d;
        if (total > TOTAL_SAT) total = TOTAL_SAT;
        m.from_trk = head;
        m.to_trk   = batch_tracks[best_i];
        m.seek_d   = best_d;
        m.total    = total[TOTAL_W-1:0];
        m.idx      = best_i[INDEX_W-1:0];
        m.last     = (k == n - 1);
        expected_moves.push_back(m);
        head = batch_tracks[best_i];
      end
      batch_tracks.delete();
    endfunction

    task check_move(input head_move_t got);
      head_move_t want;
      if (expected_moves.size() == 0) begin
        report($sformatf("move to track %0d with no request pending", got.to_trk));
        return;
      end
      want = expected_moves.pop_front();
      if (got.from_trk !== want.from_trk)
        report($sformatf("from_track %0d, expected %0d", got.from_trk, want.from_trk));
      if (got.to_trk !== want.to_trk)
        report($sformatf("to_track %0d, expected %0d", got.to_trk, want.to_trk));
      if (got.seek_d !== want.seek_d)
        report($sformatf("seek_distance %0d, expected %0d", got.seek_d, want.seek_d));
      if (got.total !== want.total)
        report($sformatf("total_seek %0d, expected %0d", got.total, want.total));
      if (got.idx !== want.idx)
        report($sformatf("request_index %0d, expected %0d", got.idx, want.idx));
      if (got.last !== want.last)
        report($sformatf("last_move %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  track_t             in_track;
  logic               in_last_request;
  logic               cfg_we;
  track_t             cfg_wdata;
  logic               out_valid;
  track_t             out_from_track;
  track_t             out_to_track;
  track_t             out_seek_distance;
  logic [TOTAL_W-1:0] out_total_seek;
  logic [INDEX_W-1:0] out_request_index;
  logic               out_last_move;

  seek_scoreboard sb;
  int unsigned    cycles = 0;
  bit             quiet = 1'b0;
  track_t         cluster_base = '0;
  int             sent;

  sstf_disk_scheduler i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_track          (in_track),
    .in_last_request   (in_last_request),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_from_track    (out_from_track),
    .out_to_track      (out_to_track),
    .out_seek_distance (out_seek_distance),
    .out_total_seek    (out_total_seek),
    .out_request_index (out_request_index),
    .out_last_move     (out_last_move)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_request(in_track, in_last_request);
    if (rst_n && out_valid) begin
      sb.check_move('{out_from_track, out_to_track, out_seek_distance, out_total_seek,
                      out_request_index, out_last_move});
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic rest_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      start           <= 1'b0;
      in_track        <= track_t'($urandom);
      in_last_request <= 1'($urandom_range(0, 1));
    end
  endtask

  task automatic send_request(input track_t trk, input logic last);
    if (!quiet && $urandom_range(0, 9) == 0) rest_sender($urandom_range(1, 3));
    @(negedge clk);
    start           <= 1'b1;
    in_track        <= trk;
    in_last_request <= last;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_moves_done();
    rest_sender(1);
    while (sb.expected_moves.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_start_track(input track_t v);
    @(negedge clk);
    start     <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= track_t'($urandom);
    sb.start_track = v;
  endtask

  function automatic track_t pick_track();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return cluster_base + track_t'($urandom_range(0, 6));
      4:       return sb.start_track ^ track_t'($urandom_range(0, 3));
      default: return track_t'($urandom);
    endcase
  endfunction

  initial begin
    int   size;
    logic last_flag;
    sb              = new();
    rst_n           = 1'b0;
    start           = 1'b0;
    in_track        = '0;
    in_last_request = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // The first batch runs from the reset head position.
    send_request(16'd0, 1'b1);
    wait_moves_done();

    set_start_track(16'hFFFF);
    send_request(16'h0000, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h8000, 1'b1);
    wait_moves_done();

    // Equal distances on both sides of the head go to the request loaded first.
    set_start_track(16'd100);
    send_request(16'd90, 1'b0);
    send_request(16'd110, 1'b0);
    send_request(16'd100, 1'b0);
    send_request(16'd90, 1'b1);
    wait_moves_done();

    set_start_track(16'd0);
    send_request(16'hFFFF, 1'b1);
    for (int i = 0; i < 6; i++) send_request(track_t'($urandom), i == 5);

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      if (sent != 0 && $urandom_range(0, 2) == 0) begin
        wait_moves_done();
        case ($urandom_range(0, 3))
          0:       set_start_track('0);
          1:       set_start_track('1);
          default: set_start_track(track_t'($urandom));
        endcase
      end
      size = (sent == 0 || $urandom_range(0, 15) == 0) ? BATCH_MAX : $urandom_range(1, 16);
      cluster_base = track_t'($urandom);
      for (int i = 0; i < size; i++) begin
        quiet     = (sent >= 80 && sent < 160);
        last_flag = (i == size - 1) && (size < BATCH_MAX || $urandom_range(0, 1) == 1);
        send_request(pick_track(), last_flag);
        sent++;
      end
    end
    wait_moves_done();

    if (sb.errors == 0 && sb.expected_moves.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
